/* hw/rtl/i128a_pkg.sv */
// Shared types and constants for the 128-bit ALU.
package i128a_pkg;

    localparam int WORD_BITS = 128;
    localparam int DIV_STEPS = WORD_BITS;
    localparam int LIMB_BITS = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_OR  = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_NOT = 4'd7;
    localparam logic [3:0] OP_SHL = 4'd8;
    localparam logic [3:0] OP_ASR = 4'd9;
    localparam logic [3:0] OP_ROL = 4'd10;
    localparam logic [3:0] OP_ROR = 4'd11;

    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_MUL,
        KIND_DIV
    } t_kind;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
        logic [7:0]  shift_amount;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        divide_by_zero;
    } t_out_item;

    // classified work: x is the finished result, the multiplicand or |a|
    typedef struct packed {
        t_kind                  kind;
        logic                   negq;
        logic                   dz;
        logic [WORD_BITS-1:0]   x;
        logic [WORD_BITS-1:0]   y;
    } t_work;

endpackage

/* hw/rtl/int128_alu.sv */
// Top level of the 128-bit ALU: front end, work queue and execution pipeline.
// Throughput: one item per cycle unless a held result stalls; every operation runs through the
// same 128-step divide pipeline: queue slot, pipeline stages 0 to 128, result register.
// Results leave in push order; a held result stalls the whole pipeline, then the queue fills.
// Reset (synchronous, active low) empties the queue and the pipeline; no payload is cleared.
module int128_alu
    import i128a_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    t_work front_work;
    t_work head_work;
    logic  q_empty;
    logic  q_rd;
    logic  out_valid;

    i128a_front u_front (
        .i_item (i_item),
        .o_work (front_work)
    );

    i128a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_work  (head_work),
        .o_empty (q_empty)
    );

    i128a_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_work   (head_work),
        .i_empty  (q_empty),
        .o_rd     (q_rd),
        .o_result (o_result),
        .o_valid  (out_valid),
        .i_pop    (pop)
    );

    assign empty = !out_valid;

endmodule

/* hw/rtl/i128a_front.sv */
// Front end: decode an item, finish the simple operations, prepare mul and div.
module i128a_front
    import i128a_pkg::*;
(
    input  t_in_item i_item,
    output t_work    o_work
);

    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    logic                 big_shift;

    assign a = {i_item.a_high, i_item.a_low};
    assign b = {i_item.b_high, i_item.b_low};
    assign big_shift = i_item.shift_amount[7];

    always_comb begin
        o_work.kind = KIND_SIMPLE;
        o_work.negq = 1'b0;
        o_work.dz   = 1'b0;
        o_work.x    = '0;
        o_work.y    = '0;
        case (i_item.opcode)
            OP_ADD: o_work.x = a + b;
            OP_SUB: o_work.x = a - b;
            OP_MUL: begin
                o_work.kind = KIND_MUL;
                o_work.x    = a;
                o_work.y    = b;
            end
            OP_DIV: begin
                if (b == '0) begin
                    o_work.dz = 1'b1;
                end else begin
                    o_work.kind = KIND_DIV;
                    o_work.negq = a[WORD_BITS-1] ^ b[WORD_BITS-1];
                    o_work.x    = a[WORD_BITS-1] ? (~a + 1'b1) : a;
                    o_work.y    = b[WORD_BITS-1] ? (~b + 1'b1) : b;
                end
            end
            OP_AND: o_work.x = a & b;
            OP_OR:  o_work.x = a | b;
            OP_XOR: o_work.x = a ^ b;
            OP_NOT: o_work.x = ~a;
            OP_SHL: o_work.x = big_shift ? '0 : (a << i_item.shift_amount[6:0]);
            OP_ASR: begin
                if (big_shift) begin
                    o_work.x = {WORD_BITS{a[WORD_BITS-1]}};
                end else begin
                    o_work.x = $signed(a) >>> i_item.shift_amount[6:0];
                end
            end
            OP_ROL: o_work.x = {a[WORD_BITS-2:0], a[WORD_BITS-1]};
            OP_ROR: o_work.x = {a[0], a[WORD_BITS-1:1]};
            default: o_work.x = '0;
        endcase
    end

endmodule

/* hw/rtl/i128a_queue.sv */
// Short queue of classified work between the front end and the execution pipeline.
module i128a_queue
    import i128a_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_rd,
    output t_work o_work,
    output logic  o_empty
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_work                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wptr, n_wptr;
    logic [PTR_BITS-1:0]  r_rptr, n_rptr;
    logic [PTR_BITS:0]    r_count, n_count;
    logic                 do_wr, do_rd;

    assign o_full  = (r_count == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_comb begin
        n_wptr  = do_wr ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_rd ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (PTR_BITS+1)'(do_wr) - (PTR_BITS+1)'(do_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_work;
        end
    end

endmodule

/* hw/rtl/i128a_back.sv */
// Execution pipeline: limb multiplier, one restoring divide step per stage, result register.
module i128a_back
    import i128a_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_work     i_work,
    input  logic      i_empty,
    output logic      o_rd,
    output t_out_item o_result,
    output logic      o_valid,
    input  logic      i_pop
);

    localparam int LIMBS    = WORD_BITS / LIMB_BITS;
    localparam int NPROD    = LIMBS * (LIMBS + 1) / 2;
    localparam int HALF     = (NPROD + 1) / 2;

    typedef struct packed {
        logic                 valid;
        t_kind                kind;
        logic                 negq;
        logic                 dz;
        logic [WORD_BITS-1:0] q;
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] den;
    } t_stage;

    t_stage                   r_stg [DIV_STEPS+1];
    t_stage                   n_stg [DIV_STEPS+1];
    logic [WORD_BITS-1:0]     r_prod [NPROD];
    logic [WORD_BITS-1:0]     r_part [2];
    logic [WORD_BITS-1:0]     n_part [2];
    t_out_item                r_out;
    logic                     r_out_valid;
    logic                     en;
    logic [WORD_BITS-1:0]     quot;

    assign en       = !r_out_valid || i_pop;
    assign o_rd     = en;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_stg[0].valid = !i_empty;
        n_stg[0].kind  = i_work.kind;
        n_stg[0].negq  = i_work.negq;
        n_stg[0].dz    = i_work.dz;
        n_stg[0].q     = i_work.x;
        n_stg[0].rem   = '0;
        n_stg[0].den   = i_work.y;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [WORD_BITS-1:0] t;
        logic [WORD_BITS:0]   diff;
        assign t    = {r_stg[k].rem[WORD_BITS-2:0], r_stg[k].q[WORD_BITS-1]};
        assign diff = {1'b0, t} - {1'b0, r_stg[k].den};
        always_comb begin
            n_stg[k+1] = r_stg[k];
            if (r_stg[k].kind == KIND_DIV) begin
                // keep the shifted remainder unless the divisor fits
                n_stg[k+1].rem = diff[WORD_BITS] ? t : diff[WORD_BITS-1:0];
                n_stg[k+1].q   = {r_stg[k].q[WORD_BITS-2:0], !diff[WORD_BITS]};
            end else if (k == 2 && r_stg[k].kind == KIND_MUL) begin
                n_stg[k+1].q = r_part[0] + r_part[1];
            end
        end
    end

    for (genvar i = 0; i < LIMBS; i++) begin : g_ai
        for (genvar j = 0; j < LIMBS - i; j++) begin : g_bj
            localparam int IDX = i * LIMBS - i * (i - 1) / 2 + j;
            logic [2*LIMB_BITS-1:0] p;
            assign p = r_stg[0].q[i*LIMB_BITS +: LIMB_BITS]
                     * r_stg[0].den[j*LIMB_BITS +: LIMB_BITS];
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_prod[IDX] <= WORD_BITS'({64'd0, p} << ((i + j) * LIMB_BITS));
                end
            end
        end
    end

    always_comb begin
        n_part[0] = '0;
        n_part[1] = '0;
        for (int m = 0; m < NPROD; m++) begin
            if (m < HALF) begin
                n_part[0] = n_part[0] + r_prod[m];
            end else begin
                n_part[1] = n_part[1] + r_prod[m];
            end
        end
    end

    assign quot = r_stg[DIV_STEPS].negq ? (~r_stg[DIV_STEPS].q + 1'b1) : r_stg[DIV_STEPS].q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) begin
                r_stg[s].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_part <= n_part;
            for (int s = 0; s <= DIV_STEPS; s++) begin
                r_stg[s] <= n_stg[s];
            end
            r_out.result_low     <= quot[63:0];
            r_out.result_high    <= quot[WORD_BITS-1:64];
            r_out.divide_by_zero <= r_stg[DIV_STEPS].dz;
            r_out_valid          <= r_stg[DIV_STEPS].valid;
        end
    end

endmodule

/* dv/tb_int128_alu.sv */
// Testbench for the 128-bit ALU: random and directed operations checked against a predictor.
module tb_int128_alu;
    import i128a_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    int128_alu dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        send_idle_pct;
    int        pop_stall_pct;
    int        error_count;
    bit        stim_done;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic t_out_item alu_predict(t_in_item it);
        t_out_item r;
        logic [127:0] a, b, v, ma, mb, q;
        logic         sa, sb;
        a = {it.a_high, it.a_low};
        b = {it.b_high, it.b_low};
        v = '0;
        r.divide_by_zero = 1'b0;
        case (it.opcode)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: v = a * b;
            OP_DIV: begin
                if (b == '0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    sa = a[127];
                    sb = b[127];
                    ma = sa ? -a : a;
                    mb = sb ? -b : b;
                    q = ma / mb;
                    v = (sa != sb) ? -q : q;
                end
            end
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_NOT: v = ~a;
            OP_SHL: v = (it.shift_amount >= 8'd128) ? '0 : a << it.shift_amount;
            OP_ASR: begin
                if (it.shift_amount >= 8'd128) begin
                    v = {128{a[127]}};
                end else begin
                    v = $signed(a) >>> it.shift_amount;
                end
            end
            OP_ROL: v = {a[126:0], a[127]};
            OP_ROR: v = {a[0], a[127:1]};
            default: v = '0;
        endcase
        r.result_low = v[63:0];
        r.result_high = v[127:64];
        return r;
    endfunction

    function automatic logic [127:0] pick_operand();
        logic [127:0] v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = {1'b1, 127'b0};
            3: v = {1'b0, {127{1'b1}}};
            4: v = 128'(v[15:0]);
            5: v = -128'(v[15:0]);
            6: v = v >> $urandom_range(0, 127);
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_item(logic [3:0] op, logic [127:0] a, logic [127:0] b,
                              logic [7:0] sh);
        t_in_item it;
        it.opcode = op;
        it.a_low = a[63:0];
        it.a_high = a[127:64];
        it.b_low = b[63:0];
        it.b_high = b[127:64];
        it.shift_amount = sh;
        pending_items.insert(pending_items.size(), it);
    endtask

    // driver: hold push and payload until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_item <= pending_items[0];
                expected_results.insert(expected_results.size(),
                                        alu_predict(pending_items.pop_front()));
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.result_low !== exp_r.result_low) begin
                    $display("%0t: result_low exp %h got %h", $time,
                             exp_r.result_low, o_result.result_low);
                    error_count++;
                end
                if (o_result.result_high !== exp_r.result_high) begin
                    $display("%0t: result_high exp %h got %h", $time,
                             exp_r.result_high, o_result.result_high);
                    error_count++;
                end
                if (o_result.divide_by_zero !== exp_r.divide_by_zero) begin
                    $display("%0t: divide_by_zero exp %b got %b", $time,
                             exp_r.divide_by_zero, o_result.divide_by_zero);
                    error_count++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    initial begin
        logic [127:0] mn;
        logic [127:0] mx;
        mn = {1'b1, 127'b0};
        mx = {1'b0, {127{1'b1}}};
        push = 1'b0;
        pop = 1'b0;
        i_item = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        error_count = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every opcode, special cases
        queue_item(OP_ADD, '1, 128'd1, 8'd0);
        queue_item(OP_SUB, mn, 128'd1, 8'd255);
        queue_item(OP_MUL, '1, '1, 8'd0);
        queue_item(OP_MUL, mx, mx, 8'd0);
        queue_item(OP_DIV, 128'd5, '0, 8'd0);
        queue_item(OP_DIV, '0, '0, 8'd0);
        queue_item(OP_DIV, mn, '1, 8'd0);
        queue_item(OP_DIV, mn, 128'd3, 8'd0);
        queue_item(OP_DIV, -128'd7, 128'd2, 8'd0);
        queue_item(OP_DIV, 128'd7, -128'd2, 8'd0);
        queue_item(OP_AND, '1, mx, 8'd0);
        queue_item(OP_OR, mn, 128'd1, 8'd0);
        queue_item(OP_XOR, '1, mn, 8'd0);
        queue_item(OP_NOT, '0, '1, 8'd0);
        queue_item(OP_SHL, '1, '0, 8'd127);
        queue_item(OP_SHL, '1, '0, 8'd128);
        queue_item(OP_SHL, '1, '0, 8'd255);
        queue_item(OP_ASR, mn, '0, 8'd0);
        queue_item(OP_ASR, mn, '0, 8'd127);
        queue_item(OP_ASR, mn, '0, 8'd128);
        queue_item(OP_ASR, mx, '0, 8'd200);
        queue_item(OP_ROL, mn, '0, 8'd0);
        queue_item(OP_ROR, 128'd1, '0, 8'd0);
        queue_item(4'd12, '1, '1, 8'd0);
        queue_item(4'd15, '1, '1, 8'd0);

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 480; n++) begin
                queue_item(4'($urandom_range(0, 15)), pick_operand(), pick_operand(),
                           ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 128)));
            end
            wait (pending_items.size() == 0);
            @(posedge i_clk);
            send_idle_pct <= (phase == 0 || phase == 3) ? 71 : (phase == 2 ? 9 : 0);
            pop_stall_pct <= (phase == 1 || phase == 3) ? 71 : (phase == 2 ? 9 : 0);
        end
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        stim_done = 1'b1;
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_int128_alu: PASS");
        end else begin
            $display("tb_int128_alu: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        if (!stim_done) begin
            $display("tb_int128_alu: FAIL");
            $finish;
        end
    end

endmodule

/* sim.f */
hw/rtl/i128a_pkg.sv
hw/rtl/i128a_front.sv
hw/rtl/i128a_queue.sv
hw/rtl/i128a_back.sv
hw/rtl/int128_alu.sv
dv/tb_int128_alu.sv
